/* rtl/psq_pkg.sv */
// psq_pkg: shared constants, codes and types of the priority ready table.
// No dependencies; psq_ctrl, psq_dpath, the top level and the bench refer to it by scoped names.
package psq_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic [15:0] THR_RESET = 16'd100;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic KIND_INSERT   = 1'b0;
	localparam logic KIND_DISPATCH = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [31:0] now;
		logic [15:0] new_task_id;
		logic [7:0]  new_priority;
		logic [15:0] new_remaining;
		logic [15:0] new_interval;
		logic [31:0] new_ready_time;
	} in_item_t;

	typedef struct packed {
		logic [15:0] task_id;
		logic [7:0]  prio;
		logic [15:0] remaining;
		logic [15:0] interval;
		logic [31:0] wait_start;
	} entry_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] task_id;
		logic [7:0]  prio;
		logic [15:0] remaining;
		logic [15:0] burst;
	} result_t;

	typedef struct packed {
		logic accept;
		logic scan;
		logic shift;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic dispatch_go;
		logic scan_done;
		logic shift_done;
		logic out_free;
	} stat_t;

endpackage

/* rtl/psq_in_if.sv */
// psq_in_if: input item channel, valid/ready with the task request payload.
// No dependencies.
interface psq_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] now;
	logic [15:0] new_task_id;
	logic [7:0]  new_priority;
	logic [15:0] new_remaining;
	logic [15:0] new_interval;
	logic [31:0] new_ready_time;

	modport source (output valid, kind, now, new_task_id, new_priority, new_remaining,
		new_interval, new_ready_time, input ready);
	modport sink (input valid, kind, now, new_task_id, new_priority, new_remaining,
		new_interval, new_ready_time, output ready);
endinterface

/* rtl/psq_out_if.sv */
// psq_out_if: result item channel, valid/ready with the dispatch result payload.
// No dependencies.
interface psq_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] out_task_id;
	logic [7:0]  out_priority;
	logic [15:0] out_remaining;
	logic [15:0] out_burst;

	modport source (output valid, status, out_task_id, out_priority, out_remaining,
		out_burst, input ready);
	modport sink (input valid, status, out_task_id, out_priority, out_remaining,
		out_burst, output ready);
endinterface

/* rtl/psq_ctrl.sv */
// psq_ctrl: sequencer of the ready table (idle, aging scan, compaction, result).
// Depends on psq_pkg for the command and status structs.
module psq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  psq_pkg::stat_t  stat,
	output psq_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} state_t;

	state_t state_q;

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == S_IDLE) && in_valid;
		cmd.scan   = (state_q == S_SCAN);
		cmd.shift  = (state_q == S_SHIFT);
		cmd.finish = (state_q == S_FINISH) && stat.out_free;
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= stat.dispatch_go ? S_SCAN : S_FINISH;
					end
				end
				S_SCAN: begin
					if (stat.scan_done) begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (stat.shift_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/psq_dpath.sv */
// psq_dpath: task table memory, aging and best-choice scan, compaction, result registers.
// Depends on psq_pkg; driven by psq_ctrl through cmd_t / stat_t.
module psq_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	input  psq_pkg::in_item_t   in_item,
	input  psq_pkg::cmd_t       cmd,
	output psq_pkg::stat_t      stat,
	output logic                out_valid,
	input  logic                out_ready,
	output psq_pkg::result_t    out_item
);

	localparam int IW = psq_pkg::IDX_W;
	localparam int CW = psq_pkg::CNT_W;

	psq_pkg::entry_t mem [psq_pkg::TABLE_DEPTH];

	logic [15:0]      thr_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    rd_ptr_q;
	logic             vld_q;
	logic [IW-1:0]    tag_q;
	psq_pkg::entry_t  rd_data_q;
	psq_pkg::entry_t  best_q;
	logic [IW-1:0]    best_idx_q;
	logic [31:0]      now_q;
	psq_pkg::result_t res_q;
	psq_pkg::result_t out_q;
	logic             out_valid_q;

	logic             issue;
	logic [IW-1:0]    rd_addr;
	logic             full;
	logic             empty;
	logic [CW-1:0]    last;
	logic [31:0]      elapsed;
	logic             hit;
	psq_pkg::entry_t  aged;
	logic             better;
	logic [IW-1:0]    best_idx_d;
	logic             wr_en;
	logic [IW-1:0]    wr_addr;
	psq_pkg::entry_t  wr_data;
	psq_pkg::entry_t  new_entry;
	logic             res_load;
	psq_pkg::result_t res_d;

	assign full    = (cnt_q == CW'(psq_pkg::TABLE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign last    = cnt_q - CW'(1);
	assign issue   = (cmd.scan || cmd.shift) && (rd_ptr_q < cnt_q);
	assign rd_addr = rd_ptr_q[IW-1:0];

	// aging of the entry returned by the read port
	assign elapsed = now_q - rd_data_q.wait_start;
	assign hit     = (now_q >= rd_data_q.wait_start) && (elapsed >= {16'b0, thr_q});
	always_comb begin
		aged = rd_data_q;
		if (hit) begin
			aged.wait_start = now_q;
			if (rd_data_q.prio != '0) begin
				aged.prio = rd_data_q.prio - 8'd1;
			end
		end
	end

	assign better = (tag_q == '0) || (aged.prio < best_q.prio) ||
		((aged.prio == best_q.prio) && (aged.remaining < best_q.remaining));
	assign best_idx_d = better ? tag_q : best_idx_q;

	assign stat.dispatch_go = (in_item.kind == psq_pkg::KIND_DISPATCH) && !empty;
	assign stat.scan_done   = cmd.scan && vld_q && (CW'(tag_q) == last);
	assign stat.shift_done  = cmd.shift &&
		((CW'(best_idx_q) == last) || (vld_q && (CW'(tag_q) == last)));
	assign stat.out_free    = !out_valid_q || out_ready;

	always_comb begin
		new_entry.task_id    = in_item.new_task_id;
		new_entry.prio       = in_item.new_priority;
		new_entry.remaining  = in_item.new_remaining;
		new_entry.interval   = in_item.new_interval;
		new_entry.wait_start = in_item.new_ready_time;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[IW-1:0];
		wr_data = new_entry;
		priority if (cmd.accept && (in_item.kind == psq_pkg::KIND_INSERT) && !full) begin
			wr_en = 1'b1;
		end else if (cmd.scan && vld_q) begin
			wr_en   = 1'b1;
			wr_addr = tag_q;
			wr_data = aged;
		end else if (cmd.shift && vld_q) begin
			wr_en   = 1'b1;
			wr_addr = tag_q - IW'(1);
			wr_data = rd_data_q;
		end
	end

	always_comb begin
		res_load = 1'b0;
		res_d    = '0;
		priority if (cmd.accept) begin
			if (in_item.kind == psq_pkg::KIND_INSERT) begin
				res_load     = 1'b1;
				res_d.status = full ? psq_pkg::ST_FULL : psq_pkg::ST_DONE;
			end else if (empty) begin
				res_load     = 1'b1;
				res_d.status = psq_pkg::ST_EMPTY;
			end
		end else if (stat.shift_done) begin
			res_load        = 1'b1;
			res_d.status    = psq_pkg::ST_DONE;
			res_d.task_id   = best_q.task_id;
			res_d.prio      = best_q.prio;
			res_d.remaining = best_q.remaining;
			res_d.burst     = (best_q.remaining < best_q.interval) ?
				best_q.remaining : best_q.interval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= psq_pkg::THR_RESET;
			cnt_q       <= '0;
			rd_ptr_q    <= '0;
			vld_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			vld_q <= issue;
			if (cmd.accept) begin
				rd_ptr_q <= '0;
				if ((in_item.kind == psq_pkg::KIND_INSERT) && !full) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end else if (stat.scan_done) begin
				rd_ptr_q <= CW'(best_idx_d) + CW'(1);
			end else if (issue) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
			end
			if (stat.shift_done) begin
				cnt_q <= last;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_q <= mem[rd_addr];
			tag_q     <= rd_addr;
		end
		if (cmd.accept) begin
			now_q <= in_item.now;
		end
		if (cmd.scan && vld_q && better) begin
			best_q     <= aged;
			best_idx_q <= tag_q;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (cmd.finish) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(psq_pkg::TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_read_live: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> (CW'(tag_q) < cnt_q))
		else $error("read of an entry past the fill level");

	a_shift_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.shift && vld_q) |-> (tag_q > best_idx_q))
		else $error("compaction moved an entry ahead of the chosen one");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before it was taken");

endmodule

/* rtl/priority_srtf_ready_queue_aging.sv */
// priority_srtf_ready_queue_aging: top level, priority ready table with aging.
// Depends on psq_pkg, psq_in_if, psq_out_if, psq_ctrl and psq_dpath.
// Insert: result registered on accept, output in the finish state; items taken only in idle.
// Dispatch on n entries: one memory read per entry for the aging scan, then one read
// per entry behind the chosen one for compaction; the result follows in the finish state.
// One table read per cycle sets the rate unless a waiting result holds the finish state.
// Reset: asynchronous, table empty, aging threshold 100; table contents are not cleared.
module priority_srtf_ready_queue_aging (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	psq_in_if.sink      req,
	psq_out_if.source   rsp
);

	psq_pkg::in_item_t in_item;
	psq_pkg::result_t  out_item;
	psq_pkg::cmd_t     cmd;
	psq_pkg::stat_t    stat;
	logic              in_ready;
	logic              out_valid;

	always_comb begin
		in_item.kind           = req.kind;
		in_item.now            = req.now;
		in_item.new_task_id    = req.new_task_id;
		in_item.new_priority   = req.new_priority;
		in_item.new_remaining  = req.new_remaining;
		in_item.new_interval   = req.new_interval;
		in_item.new_ready_time = req.new_ready_time;
	end

	assign req.ready         = in_ready;
	assign rsp.valid         = out_valid;
	assign rsp.status        = out_item.status;
	assign rsp.out_task_id   = out_item.task_id;
	assign rsp.out_priority  = out_item.prio;
	assign rsp.out_remaining = out_item.remaining;
	assign rsp.out_burst     = out_item.burst;

	psq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	psq_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_item     (in_item),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (rsp.ready),
		.out_item    (out_item)
	);

endmodule

/* tb/sv/tb_priority_srtf_ready_queue_aging.sv */
// tb_priority_srtf_ready_queue_aging: self-checking bench for the aging priority ready table.
// Drives task items through psq_in_if and checks results on psq_out_if against its own
// scheduler model; depends on psq_pkg, psq_in_if, psq_out_if and the top level.
module tb_priority_srtf_ready_queue_aging;

	localparam int DEPTH       = psq_pkg::TABLE_DEPTH;
	localparam int IDLE_PCT    = 34;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE      = 60;
	localparam int LIMIT       = 400000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	psq_in_if  req_if ();
	psq_out_if rsp_if ();

	priority_srtf_ready_queue_aging dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_if),
		.rsp         (rsp_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	psq_pkg::in_item_t  task_reqs[$];
	psq_pkg::result_t   due_results[$];

	psq_pkg::entry_t    tbl [DEPTH];
	int                 tbl_count;
	logic [15:0]        age_thr;

	logic               req_taken;
	bit                 no_idle;
	int                 hold_reqs;
	int                 holds_served;
	int                 hold_left;
	int                 fail_count;
	int                 cycles;

	logic [31:0]        sim_clock;
	int                 mode_left;
	int                 ins_pct;

	function automatic psq_pkg::result_t sched_result(psq_pkg::in_item_t it);
		psq_pkg::result_t r;
		int i;
		int best;
		r = '0;
		if (it.kind == psq_pkg::KIND_INSERT) begin
			if (tbl_count >= DEPTH) begin
				r.status = psq_pkg::ST_FULL;
			end else begin
				tbl[tbl_count].task_id    = it.new_task_id;
				tbl[tbl_count].prio       = it.new_priority;
				tbl[tbl_count].remaining  = it.new_remaining;
				tbl[tbl_count].interval   = it.new_interval;
				tbl[tbl_count].wait_start = it.new_ready_time;
				tbl_count++;
				r.status = psq_pkg::ST_DONE;
			end
			return r;
		end
		for (i = 0; i < tbl_count; i++) begin
			if (it.now >= tbl[i].wait_start &&
					(it.now - tbl[i].wait_start) >= {16'd0, age_thr}) begin
				if (tbl[i].prio != 8'd0)
					tbl[i].prio = tbl[i].prio - 8'd1;
				tbl[i].wait_start = it.now;
			end
		end
		if (tbl_count == 0) begin
			r.status = psq_pkg::ST_EMPTY;
			return r;
		end
		best = 0;
		for (i = 1; i < tbl_count; i++) begin
			if (tbl[i].prio < tbl[best].prio)
				best = i;
			else if (tbl[i].prio == tbl[best].prio && tbl[i].remaining < tbl[best].remaining)
				best = i;
		end
		r.status    = psq_pkg::ST_DONE;
		r.task_id   = tbl[best].task_id;
		r.prio      = tbl[best].prio;
		r.remaining = tbl[best].remaining;
		r.burst     = (tbl[best].remaining < tbl[best].interval) ?
			tbl[best].remaining : tbl[best].interval;
		for (i = best; i + 1 < tbl_count; i++)
			tbl[i] = tbl[i + 1];
		tbl_count--;
		return r;
	endfunction

	function automatic psq_pkg::in_item_t mk_insert(logic [15:0] id, logic [7:0] pr,
			logic [15:0] rem, logic [15:0] ivl, logic [31:0] rt);
		psq_pkg::in_item_t it;
		it.kind           = psq_pkg::KIND_INSERT;
		it.now            = $urandom;
		it.new_task_id    = id;
		it.new_priority   = pr;
		it.new_remaining  = rem;
		it.new_interval   = ivl;
		it.new_ready_time = rt;
		return it;
	endfunction

	function automatic psq_pkg::in_item_t mk_dispatch(logic [31:0] t_now);
		psq_pkg::in_item_t it;
		it.kind           = psq_pkg::KIND_DISPATCH;
		it.now            = t_now;
		it.new_task_id    = 16'($urandom);
		it.new_priority   = 8'($urandom);
		it.new_remaining  = 16'($urandom);
		it.new_interval   = 16'($urandom);
		it.new_ready_time = $urandom;
		return it;
	endfunction

	function automatic logic [15:0] pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 75)
			return 16'($urandom_range(24, 1));
		if (r < 83)
			return 16'd0;
		return 16'($urandom_range(65535, 1));
	endfunction

	task automatic note_fail(string msg);
		if (fail_count < 10)
			$display("%s", msg);
		fail_count++;
	endtask

	// mostly well-formed traffic on a rising clock, in insert-heavy / balanced / dispatch-heavy runs
	task automatic gen_items(int n);
		int k;
		psq_pkg::in_item_t it;
		logic [7:0]   pr;
		logic [31:0]  rt;
		logic [127:0] raw;
		for (k = 0; k < n; k++) begin
			if (mode_left == 0) begin
				case ($urandom_range(2))
					0: ins_pct = 55;
					1: ins_pct = 85;
					default: ins_pct = 20;
				endcase
				mode_left = $urandom_range(40, 10);
			end
			mode_left--;
			if ($urandom_range(99) < 8) begin
				raw = {$urandom, $urandom, $urandom, $urandom};
				it  = raw[$bits(psq_pkg::in_item_t)-1:0];
			end else if ($urandom_range(99) < ins_pct) begin
				pr = ($urandom_range(99) < 70) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
				rt = ($urandom_range(99) < 85) ? sim_clock - 32'($urandom_range(250)) : $urandom;
				it = mk_insert(16'($urandom_range(65535)), pr, pick_len(), pick_len(), rt);
			end else begin
				it = mk_dispatch(($urandom_range(99) < 10) ? $urandom : sim_clock);
			end
			task_reqs.push_back(it);
			sim_clock = sim_clock + 32'($urandom_range(120));
		end
	endtask

	task automatic wait_idle();
		while (task_reqs.size() != 0 || due_results.size() != 0)
			@(posedge clk);
		do @(posedge clk); while (!req_if.ready);
	endtask

	task automatic set_threshold(logic [15:0] v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		age_thr = v;
	endtask

	// input side: hold an offered item until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!(req_if.valid && !req_taken)) begin
			if (req_taken)
				void'(task_reqs.pop_front());
			if (task_reqs.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
				req_if.valid          <= 1'b1;
				req_if.kind           <= task_reqs[0].kind;
				req_if.now            <= task_reqs[0].now;
				req_if.new_task_id    <= task_reqs[0].new_task_id;
				req_if.new_priority   <= task_reqs[0].new_priority;
				req_if.new_remaining  <= task_reqs[0].new_remaining;
				req_if.new_interval   <= task_reqs[0].new_interval;
				req_if.new_ready_time <= task_reqs[0].new_ready_time;
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// output side: random back-pressure plus requested long hold-offs
	always @(negedge clk) begin
		if (hold_reqs != holds_served) begin
			holds_served = hold_reqs;
			hold_left    = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		psq_pkg::in_item_t it;
		psq_pkg::result_t  got;
		psq_pkg::result_t  want;
		if (arst_n && req_if.valid && req_if.ready) begin
			it.kind           = req_if.kind;
			it.now            = req_if.now;
			it.new_task_id    = req_if.new_task_id;
			it.new_priority   = req_if.new_priority;
			it.new_remaining  = req_if.new_remaining;
			it.new_interval   = req_if.new_interval;
			it.new_ready_time = req_if.new_ready_time;
			due_results.push_back(sched_result(it));
		end
		req_taken <= arst_n && req_if.valid && req_if.ready;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got.status    = rsp_if.status;
			got.task_id   = rsp_if.out_task_id;
			got.prio      = rsp_if.out_priority;
			got.remaining = rsp_if.out_remaining;
			got.burst     = rsp_if.out_burst;
			if (due_results.size() == 0) begin
				note_fail($sformatf("unexpected result st=%0d id=%0d pr=%0d rem=%0d burst=%0d",
					got.status, got.task_id, got.prio, got.remaining, got.burst));
			end else begin
				want = due_results.pop_front();
				if (got !== want)
					note_fail($sformatf({"result mismatch: exp st=%0d id=%0d pr=%0d rem=%0d ",
						"burst=%0d, got st=%0d id=%0d pr=%0d rem=%0d burst=%0d"},
						want.status, want.task_id, want.prio, want.remaining, want.burst,
						got.status, got.task_id, got.prio, got.remaining, got.burst));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int k;
		arst_n                = 1'b0;
		cfg_wr_en             = 1'b0;
		cfg_wr_data           = '0;
		req_if.valid          = 1'b0;
		req_if.kind           = psq_pkg::KIND_INSERT;
		req_if.now            = '0;
		req_if.new_task_id    = '0;
		req_if.new_priority   = '0;
		req_if.new_remaining  = '0;
		req_if.new_interval   = '0;
		req_if.new_ready_time = '0;
		rsp_if.ready          = 1'b0;
		req_taken             = 1'b0;
		no_idle               = 1'b0;
		hold_reqs             = 0;
		holds_served          = 0;
		hold_left             = 0;
		fail_count            = 0;
		cycles                = 0;
		tbl_count             = 0;
		age_thr               = psq_pkg::THR_RESET;
		mode_left             = 0;
		ins_pct               = 55;
		sim_clock             = 32'($urandom_range(5000, 1000));
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty dispatch, field extremes, ties, full table, future ready time
		task_reqs.push_back(mk_dispatch(32'd0));
		task_reqs.push_back(mk_insert(16'd0, 8'd0, 16'd1, 16'hFFFF, 32'd0));
		task_reqs.push_back(mk_insert(16'hFFFF, 8'hFF, 16'hFFFF, 16'd1, 32'hFFFF_FFFF));
		task_reqs.push_back(mk_insert(16'd3, 8'd5, 16'd0, 16'd9, 32'd10));
		task_reqs.push_back(mk_insert(16'd4, 8'd5, 16'd7, 16'd0, 32'd10));
		task_reqs.push_back(mk_insert(16'd5, 8'd5, 16'd7, 16'd3, 32'd20));
		for (k = 0; k < 11; k++)
			task_reqs.push_back(mk_insert(16'(10 + k), 8'(6 + k % 3), 16'(30 - k), 16'd8,
				32'(50 * k)));
		task_reqs.push_back(mk_insert(16'd99, 8'd0, 16'd1, 16'd1, 32'd0));
		task_reqs.push_back(mk_dispatch(32'd0));
		task_reqs.push_back(mk_dispatch(32'd256));
		task_reqs.push_back(mk_dispatch(32'hFFFF_FFFF));
		task_reqs.push_back(mk_dispatch(32'hFFFF_FFFF));
		task_reqs.push_back(mk_insert(16'h8000, 8'h80, 16'h8000, 16'h7FFF, 32'h8000_0000));
		wait_idle();

		set_threshold(16'd0);
		no_idle = 1'b1;
		gen_items(180);
		wait_idle();
		no_idle = 1'b0;

		set_threshold(16'hFFFF);
		gen_items(190);
		hold_reqs++;
		wait_idle();

		set_threshold(16'd1);
		gen_items(190);
		wait_idle();

		for (k = 0; k < 3; k++) begin
			set_threshold(16'($urandom_range(300, 2)));
			gen_items(190);
			wait_idle();
		end

		while (task_reqs.size() != 0 || due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* priority_srtf_ready_queue_aging.f */
rtl/psq_pkg.sv
rtl/psq_in_if.sv
rtl/psq_out_if.sv
rtl/psq_ctrl.sv
rtl/psq_dpath.sv
rtl/priority_srtf_ready_queue_aging.sv
tb/sv/tb_priority_srtf_ready_queue_aging.sv
